@@ sv/bgi_pkg.sv @@
// Package: types, constants and codes shared by the grid interpolator modules
`timescale 1ns / 1ps
`default_nettype none
package bgi_pkg;
   localparam int XBits = 6;
   localparam int YBits = 6;
   localparam int XMax = 1 << XBits;
   localparam int YMax = 1 << YBits;
   localparam int GBits = XBits + YBits;
   localparam int GDepth = 1 << GBits;
   localparam int CntXBits = XBits + 1;
   localparam int CntYBits = YBits + 1;
   localparam int CntGBits = GBits + 1;
   localparam int QDepth = 2;

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_SMALL = 3'd1,
      ST_EQUAL = 3'd2,
      ST_OVFL  = 3'd3,
      ST_SAT   = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] sample_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] interp_result;
      logic [2:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [CntXBits-1:0] x_count;
      logic [CntYBits-1:0] y_count;
      logic [CntGBits-1:0] point_count;
      logic                overflow;
   } grid_info_type;

   typedef enum logic [4:0] {
      B_IDLE, B_CHECK, B_SCANX, B_SCANY, B_CELL, B_AXREAD, B_AXWAIT, B_AYREAD, B_AYWAIT,
      B_G0, B_G1, B_G2, B_G3, B_GWAIT, B_L1, B_L2, B_L3, B_OUT
   } back_state_type;
endpackage
`default_nettype wire

@@ sv/bilinear_grid_interpolator_core.sv @@
// Top level: bilinear interpolator over a loaded rectilinear grid
// Clears and loads are accepted once no query is queued or running; a
// query waits in a two-entry queue and starts once any earlier result has been
// taken. It then scans each axis RAM at one entry per cycle, goes through
// checks, axis and grid reads and hand-off, and runs each linear step in the
// one bit-serial divider: three steps in general, one when y clamps to the top
// row.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_grid_interpolator_core import bgi_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   logic q_valid, q_pop, back_busy;
   logic signed [31:0] q_x, q_y, w_x, w_y, w_z, xr_data, yr_data, gr_data;
   grid_info_type info;
   logic xw_en, yw_en, gw_en;
   logic [XBits-1:0] xw_addr, xr_addr;
   logic [YBits-1:0] yw_addr, yr_addr;
   logic [GBits-1:0] gw_addr, gr_addr;

   bgi_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_valid, .q_pop, .q_x, .q_y, .back_busy, .info,
      .xw_en, .xw_addr, .yw_en, .yw_addr, .gw_en, .gw_addr, .w_x, .w_y, .w_z
   );

   bgi_ram #(.Width(32), .Depth(XMax)) u_xram (
      .clock, .wr_en(xw_en), .wr_addr(xw_addr), .wr_data(w_x),
      .rd_addr(xr_addr), .rd_data(xr_data)
   );
   bgi_ram #(.Width(32), .Depth(YMax)) u_yram (
      .clock, .wr_en(yw_en), .wr_addr(yw_addr), .wr_data(w_y),
      .rd_addr(yr_addr), .rd_data(yr_data)
   );
   bgi_ram #(.Width(32), .Depth(GDepth)) u_gram (
      .clock, .wr_en(gw_en), .wr_addr(gw_addr), .wr_data(w_z),
      .rd_addr(gr_addr), .rd_data(gr_data)
   );

   bgi_back u_back (
      .clock, .reset, .q_valid, .q_pop, .q_x, .q_y, .info, .busy(back_busy),
      .xr_addr, .xr_data, .yr_addr, .yr_data, .gr_addr, .gr_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule
`default_nettype wire

@@ sv/bgi_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module bgi_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ sv/bgi_front.sv @@
// Front end: accepts items, performs clears and loads, queues queries
`timescale 1ns / 1ps
`default_nettype none
module bgi_front import bgi_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req_data,
   output logic                     q_valid,
   input  wire logic                q_pop,
   output logic signed [31:0]       q_x,
   output logic signed [31:0]       q_y,
   input  wire logic                back_busy,
   output grid_info_type            info,
   output logic                     xw_en,
   output logic [XBits-1:0]         xw_addr,
   output logic                     yw_en,
   output logic [YBits-1:0]         yw_addr,
   output logic                     gw_en,
   output logic [GBits-1:0]         gw_addr,
   output logic signed [31:0]       w_x,
   output logic signed [31:0]       w_y,
   output logic signed [31:0]       w_z
);
   logic [CntXBits-1:0] x_count_ff, x_count_in;
   logic [CntYBits-1:0] y_count_ff, y_count_in;
   logic [CntGBits-1:0] pt_count_ff, pt_count_in;
   logic signed [31:0]  last_x_ff, last_x_in;
   logic                first_run_ff, first_run_in;
   logic                ovfl_ff, ovfl_in;
   logic signed [31:0]  qx_ff [QDepth];
   logic signed [31:0]  qy_ff [QDepth];
   logic                wp_ff, rp_ff;
   logic [1:0]          cnt_ff;
   logic                accept, is_query, push, grid_change, pending;

   assign is_query = req_data.kind == KIND_QUERY;
   // grid updates wait until no query is queued or being worked on
   assign pending = (cnt_ff != 2'd0) || back_busy;
   assign req_ready = is_query ? (cnt_ff != 2'(QDepth)) : !pending;
   assign accept = req_valid && req_ready;
   assign push = accept && is_query;
   assign grid_change = accept && (req_data.kind == KIND_LOAD);

   assign w_x = req_data.coord_x;
   assign w_y = req_data.coord_y;
   assign w_z = req_data.sample_value;

   always_comb begin
      x_count_in = x_count_ff;
      y_count_in = y_count_ff;
      pt_count_in = pt_count_ff;
      last_x_in = last_x_ff;
      first_run_in = first_run_ff;
      ovfl_in = ovfl_ff;
      xw_en = 1'b0;
      yw_en = 1'b0;
      gw_en = 1'b0;
      xw_addr = '0;
      yw_addr = '0;
      gw_addr = pt_count_ff[GBits-1:0];
      if (accept && req_data.kind == KIND_CLEAR) begin
         x_count_in = '0;
         y_count_in = '0;
         pt_count_in = '0;
         last_x_in = '0;
         first_run_in = 1'b1;
         ovfl_in = 1'b0;
      end else if (grid_change) begin
         if (pt_count_ff == '0) begin
            xw_en = 1'b1;
            yw_en = 1'b1;
            x_count_in = CntXBits'(1);
            y_count_in = CntYBits'(1);
            first_run_in = 1'b1;
            last_x_in = req_data.coord_x;
         end else if (req_data.coord_x != last_x_ff) begin
            first_run_in = 1'b0;
            last_x_in = req_data.coord_x;
            if (x_count_ff < CntXBits'(XMax)) begin
               xw_en = 1'b1;
               xw_addr = x_count_ff[XBits-1:0];
               x_count_in = x_count_ff + 1'b1;
            end else begin
               ovfl_in = 1'b1;
            end
         end else if (first_run_ff) begin
            if (y_count_ff < CntYBits'(YMax)) begin
               yw_en = 1'b1;
               yw_addr = y_count_ff[YBits-1:0];
               y_count_in = y_count_ff + 1'b1;
            end else begin
               ovfl_in = 1'b1;
            end
         end
         if (pt_count_ff < CntGBits'(GDepth)) begin
            gw_en = 1'b1;
            pt_count_in = pt_count_ff + 1'b1;
         end else begin
            ovfl_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_count_ff <= '0;
         y_count_ff <= '0;
         pt_count_ff <= '0;
         last_x_ff <= '0;
         first_run_ff <= 1'b1;
         ovfl_ff <= 1'b0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         x_count_ff <= x_count_in;
         y_count_ff <= y_count_in;
         pt_count_ff <= pt_count_in;
         last_x_ff <= last_x_in;
         first_run_ff <= first_run_in;
         ovfl_ff <= ovfl_in;
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (q_pop) begin
            rp_ff <= !rp_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         qx_ff[wp_ff] <= req_data.coord_x;
         qy_ff[wp_ff] <= req_data.coord_y;
      end
   end

   assign q_valid = cnt_ff != 2'd0;
   assign q_x = qx_ff[rp_ff];
   assign q_y = qy_ff[rp_ff];
   assign info = '{x_count: x_count_ff, y_count: y_count_ff,
                   point_count: pt_count_ff, overflow: ovfl_ff};

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'(QDepth) |-> !push || q_pop) else $error("query queue overrun");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> cnt_ff != 2'd0) else $error("query queue underrun");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      grid_change |-> !pending) else $error("load while query pending");
endmodule
`default_nettype wire

@@ sv/bgi_div.sv @@
// Sequential unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module bgi_div import bgi_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [32:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);
   logic [63:0] q_ff, q_in;
   logic [33:0] r_ff, r_in;
   logic [32:0] d_ff;
   logic [6:0]  n_ff, n_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      n_in = n_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[32:0], q_ff[63]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         n_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = {r_ff[32:0], q_ff[63]};
            q_in = {q_ff[62:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         n_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         n_ff <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) begin
         d_ff <= divisor;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

@@ sv/bgi_back.sv @@
// Back end: cell search and bilinear steps for queued queries
`timescale 1ns / 1ps
`default_nettype none
module bgi_back import bgi_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   output logic                     q_pop,
   input  wire logic signed [31:0]  q_x,
   input  wire logic signed [31:0]  q_y,
   input  wire grid_info_type       info,
   output logic                     busy,
   output logic [XBits-1:0]         xr_addr,
   input  wire logic signed [31:0]  xr_data,
   output logic [YBits-1:0]         yr_addr,
   input  wire logic signed [31:0]  yr_data,
   output logic [GBits-1:0]         gr_addr,
   input  wire logic signed [31:0]  gr_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_data
);
   back_state_type st_ff, st_in;
   logic signed [31:0] x_ff, y_ff;
   logic [CntXBits-1:0] i_ff, i_in;
   logic [CntYBits-1:0] j_ff, j_in;
   logic rd_ok_ff, rd_ok_in;
   logic [XBits-1:0] cx_ff, cx_in;
   logic [YBits-1:0] cy_ff, cy_in;
   logic clamp_ff, clamp_in;
   logic signed [31:0] xlo_ff, xlo_in, ylo_ff, ylo_in;
   logic signed [32:0] xnum_ff, xnum_in, ynum_ff, ynum_in, xden_ff, xden_in, yden_ff, yden_in;
   logic signed [31:0] g_ff [4];
   logic [1:0] gi_ff, gi_in;
   logic signed [31:0] f1_ff, f1_in, f2_ff, f2_in;
   logic sat_ff, sat_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in;
   logic signed [32:0] num_ff, num_in, den_ff, den_in;
   logic [63:0] prod_ff;
   logic neg_ff;
   logic div_start;
   logic div_done;
   logic [63:0] quo;
   logic [1:0] step_ff, step_in;
   logic out_v_ff, out_v_in;
   rsp_type out_ff, out_in;
   logic [GBits-1:0] gaddr;
   logic [CntGBits-1:0] area;
   logic [XBits-1:0] ga;
   logic [YBits-1:0] gb;
   logic signed [33:0] diff;
   logic signed [34:0] res;
   logic [32:0] dmag, nmag, demag;
   logic [33:0] qcap;
   logic signed [31:0] res_sat;
   logic res_is_sat;

   assign area = CntGBits'(info.x_count) * CntGBits'(info.y_count);

   always_comb begin
      ga = cx_ff;
      gb = clamp_ff ? YBits'(info.y_count - 1'b1) : cy_ff;
      case (gi_ff)
         2'd1: gb = clamp_ff ? gb : cy_ff + 1'b1;
         2'd2: ga = cx_ff + 1'b1;
         2'd3: begin
            ga = cx_ff + 1'b1;
            gb = clamp_ff ? gb : cy_ff + 1'b1;
         end
         default: ;
      endcase
      gaddr = GBits'(ga) * GBits'(info.y_count[YBits-1:0]) + GBits'(gb);
      if (info.y_count == CntYBits'(YMax)) begin
         gaddr = {ga, gb};
      end
   end

   always_ff @(posedge clock) begin
      diff <= {{2{b_in[31]}}, b_in} - {{2{a_in[31]}}, a_in};
   end

   assign dmag = diff[33] ? 33'(-diff) : 33'(diff);
   assign nmag = num_ff[32] ? 33'(-num_ff) : 33'(num_ff);
   assign demag = den_ff[32] ? 33'(-den_ff) : 33'(den_ff);
   assign qcap = (quo > 64'h2_0000_0000) ? 34'h2_0000_0000 : quo[33:0];
   assign res = neg_ff ? {{3{a_ff[31]}}, a_ff} - $signed({1'b0, qcap})
                       : {{3{a_ff[31]}}, a_ff} + $signed({1'b0, qcap});
   assign res_is_sat = (res > 35'sh0_7FFF_FFFF) || (res < -35'sh0_8000_0000);
   assign res_sat = res_is_sat ? (res[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : res[31:0];

   bgi_div u_div (
      .clock, .reset, .start(div_start),
      .dividend(prod_ff), .divisor(demag), .done(div_done), .quotient(quo)
   );

   always_comb begin
      st_in = st_ff;
      i_in = i_ff;
      j_in = j_ff;
      rd_ok_in = 1'b0;
      cx_in = cx_ff;
      cy_in = cy_ff;
      clamp_in = clamp_ff;
      xlo_in = xlo_ff;
      ylo_in = ylo_ff;
      xnum_in = xnum_ff;
      ynum_in = ynum_ff;
      xden_in = xden_ff;
      yden_in = yden_ff;
      gi_in = gi_ff;
      f1_in = f1_ff;
      f2_in = f2_ff;
      sat_in = sat_ff;
      a_in = a_ff;
      b_in = b_ff;
      num_in = num_ff;
      den_in = den_ff;
      step_in = step_ff;
      out_v_in = out_v_ff;
      out_in = out_ff;
      q_pop = 1'b0;
      div_start = 1'b0;
      xr_addr = i_ff[XBits-1:0];
      yr_addr = j_ff[YBits-1:0];
      if (out_v_ff && rsp_ready) begin
         out_v_in = 1'b0;
      end
      case (st_ff)
         B_IDLE: begin
            if (q_valid && (!out_v_ff || rsp_ready)) begin
               q_pop = 1'b1;
               st_in = B_CHECK;
            end
         end
         B_CHECK: begin
            i_in = '0;
            j_in = '0;
            sat_in = 1'b0;
            if (info.overflow) begin
               out_in = '{interp_result: '0, status: ST_OVFL};
               st_in = B_OUT;
            end else if (info.x_count < CntXBits'(2) || info.y_count < CntYBits'(2)
                         || info.point_count < area) begin
               out_in = '{interp_result: '0, status: ST_SMALL};
               st_in = B_OUT;
            end else begin
               st_in = B_SCANX;
            end
         end
         B_SCANX: begin
            xr_addr = i_ff[XBits-1:0];
            if (rd_ok_ff && !(xr_data < x_ff)) begin
               st_in = B_SCANY;
            end else if (rd_ok_ff && i_ff + 1'b1 == info.x_count) begin
               i_in = info.x_count;
               st_in = B_SCANY;
            end else begin
               if (rd_ok_ff) begin
                  i_in = i_ff + 1'b1;
               end
               rd_ok_in = 1'b1;
               xr_addr = rd_ok_ff ? XBits'(i_ff + 1'b1) : i_ff[XBits-1:0];
            end
            if (st_in == B_SCANY) begin
               rd_ok_in = 1'b0;
            end
         end
         B_SCANY: begin
            yr_addr = j_ff[YBits-1:0];
            if (rd_ok_ff && !(yr_data <= y_ff)) begin
               st_in = B_CELL;
            end else if (rd_ok_ff && j_ff + 1'b1 == info.y_count) begin
               j_in = info.y_count;
               st_in = B_CELL;
            end else begin
               if (rd_ok_ff) begin
                  j_in = j_ff + 1'b1;
               end
               rd_ok_in = 1'b1;
               yr_addr = rd_ok_ff ? YBits'(j_ff + 1'b1) : j_ff[YBits-1:0];
            end
            if (st_in == B_CELL) begin
               rd_ok_in = 1'b0;
            end
         end
         B_CELL: begin
            cx_in = (i_ff == '0) ? '0 : XBits'(i_ff - 1'b1);
            if ((i_ff == '0 ? CntXBits'(0) : i_ff - 1'b1) > info.x_count - CntXBits'(2)) begin
               cx_in = XBits'(info.x_count - CntXBits'(2));
            end
            clamp_in = j_ff >= info.y_count;
            cy_in = (j_ff == '0) ? '0 : YBits'(j_ff - 1'b1);
            st_in = B_AXREAD;
         end
         B_AXREAD: begin
            xr_addr = cx_ff;
            yr_addr = cy_ff;
            st_in = B_AXWAIT;
         end
         B_AXWAIT: begin
            xlo_in = xr_data;
            ylo_in = yr_data;
            xnum_in = {x_ff[31], x_ff} - {xr_data[31], xr_data};
            ynum_in = {y_ff[31], y_ff} - {yr_data[31], yr_data};
            xr_addr = cx_ff + 1'b1;
            yr_addr = cy_ff + 1'b1;
            st_in = B_AYREAD;
         end
         B_AYREAD: begin
            xr_addr = cx_ff + 1'b1;
            yr_addr = cy_ff + 1'b1;
            st_in = B_AYWAIT;
         end
         B_AYWAIT: begin
            xden_in = {xr_data[31], xr_data} - {xlo_ff[31], xlo_ff};
            yden_in = {yr_data[31], yr_data} - {ylo_ff[31], ylo_ff};
            if (xr_data == xlo_ff || (!clamp_ff && yr_data == ylo_ff)) begin
               out_in = '{interp_result: '0, status: ST_EQUAL};
               st_in = B_OUT;
            end else begin
               gi_in = 2'd0;
               st_in = B_G0;
            end
         end
         B_G0, B_G1, B_G2, B_G3: begin
            gi_in = gi_ff + 1'b1;
            st_in = back_state_type'(st_ff + 1'b1);
            if (st_ff == B_G3) begin
               st_in = B_GWAIT;
            end
         end
         B_GWAIT: begin
            if (clamp_ff) begin
               a_in = g_ff[0];
               b_in = g_ff[2];
               num_in = xnum_ff;
               den_in = xden_ff;
               step_in = 2'd2;
            end else begin
               a_in = g_ff[0];
               b_in = g_ff[1];
               num_in = ynum_ff;
               den_in = yden_ff;
               step_in = 2'd0;
            end
            st_in = B_L1;
         end
         B_L1: begin
            st_in = B_L2;
         end
         B_L2: begin
            div_start = 1'b1;
            st_in = B_L3;
         end
         B_L3: begin
            if (div_done) begin
               sat_in = sat_ff || res_is_sat;
               case (step_ff)
                  2'd0: begin
                     f1_in = res_sat;
                     a_in = g_ff[2];
                     b_in = g_ff[3];
                     step_in = 2'd1;
                     st_in = B_L1;
                  end
                  2'd1: begin
                     f2_in = res_sat;
                     a_in = f1_ff;
                     b_in = res_sat;
                     num_in = xnum_ff;
                     den_in = xden_ff;
                     step_in = 2'd2;
                     st_in = B_L1;
                  end
                  default: begin
                     out_in.interp_result = res_sat;
                     out_in.status = (sat_ff || res_is_sat) ? ST_SAT : ST_OK;
                     st_in = B_OUT;
                  end
               endcase
            end
         end
         B_OUT: begin
            if (!out_v_ff || rsp_ready) begin
               out_v_in = 1'b1;
               st_in = B_IDLE;
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= B_IDLE;
         out_v_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         out_v_ff <= out_v_in;
         rd_ok_ff <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         x_ff <= q_x;
         y_ff <= q_y;
      end
      if (st_ff == B_G1 || st_ff == B_G2 || st_ff == B_G3 || st_ff == B_GWAIT) begin
         g_ff[gi_ff - 2'd1] <= gr_data;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      clamp_ff <= clamp_in;
      xlo_ff <= xlo_in;
      ylo_ff <= ylo_in;
      xnum_ff <= xnum_in;
      ynum_ff <= ynum_in;
      xden_ff <= xden_in;
      yden_ff <= yden_in;
      gi_ff <= gi_in;
      f1_ff <= f1_in;
      f2_ff <= f2_in;
      sat_ff <= sat_in;
      a_ff <= a_in;
      b_ff <= b_in;
      num_ff <= num_in;
      den_ff <= den_in;
      step_ff <= step_in;
      out_ff <= out_in;
      if (st_ff == B_L1) begin
         prod_ff <= 64'(dmag) * 64'(nmag);
         neg_ff <= (diff[33] != num_ff[32]) != den_ff[32];
      end
   end

   assign gr_addr = gaddr;
   assign busy = st_ff != B_IDLE;
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> st_ff == B_IDLE) else $error("pop while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_ready |=> out_v_ff && $stable(out_ff)) else $error("result lost");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_start |=> st_ff == B_L3) else $error("divider start out of step");
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench for the bilinear grid interpolator core: directed table, then random grids, overflow runs and single items
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import bgi_pkg::*;

   localparam int WatchLimit = 20000;
   localparam int TailCycles = 600;
   localparam int ItemTarget = 1800;
   localparam int GridSlots = XMax * YMax;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type pending_rsp[$];
   int      fail_cnt = 0;
   int      item_cnt = 0;
   int      idle_phase = 0;
   int      quiet_cycles = 0;
   bit      hold_off_req = 1'b0;
   int      hold_left = 0;

   longint  x_axis[XMax];
   longint  y_axis[YMax];
   longint  z_grid[GridSlots];
   int      nx, ny, npts;
   longint  prev_x;
   bit      first_run, load_ovf;

   bilinear_grid_interpolator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   function automatic bit [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint lerp_step(longint a, longint b, longint num, longint den,
                                        inout bit sat);
      longint    d;
      bit        neg;
      bit [63:0] q;
      longint    r;
      d = b - a;
      neg = ((d < 0) != (num < 0)) != (den < 0);
      q = (magnitude(d) * magnitude(num)) / magnitude(den);
      if (q > 64'(1) << 33) q = 64'(1) << 33;
      r = neg ? a - longint'(q) : a + longint'(q);
      if (r > 64'sd2147483647) begin
         sat = 1'b1;
         r = 64'sd2147483647;
      end
      if (r < -64'sd2147483648) begin
         sat = 1'b1;
         r = -64'sd2147483648;
      end
      return r;
   endfunction

   function automatic longint grid_at(int a, int b);
      return z_grid[(a * ny + b) % GridSlots];
   endfunction

   function automatic rsp_type interpolate(longint x, longint y);
      rsp_type o;
      int      i, j, cx, cy;
      longint  f1, f2, xlo, xhi, ylo, yhi;
      bit      sat;
      o = '0;
      sat = 1'b0;
      i = 0;
      j = 0;
      if (load_ovf) begin
         o.status = ST_OVFL;
         return o;
      end
      if (nx < 2 || ny < 2 || npts < nx * ny) begin
         o.status = ST_SMALL;
         return o;
      end
      while (i < nx && x_axis[i] < x) i++;
      while (j < ny && y_axis[j] <= y) j++;
      cx = (i == 0) ? 0 : i - 1;
      if (cx > nx - 2) cx = nx - 2;
      xlo = x_axis[cx];
      xhi = x_axis[cx + 1];
      if (xhi == xlo) begin
         o.status = ST_EQUAL;
         return o;
      end
      if (j >= ny) begin
         f1 = grid_at(cx, ny - 1);
         f2 = grid_at(cx + 1, ny - 1);
      end else begin
         cy = (j == 0) ? 0 : j - 1;
         ylo = y_axis[cy];
         yhi = y_axis[cy + 1];
         if (yhi == ylo) begin
            o.status = ST_EQUAL;
            return o;
         end
         f1 = lerp_step(grid_at(cx, cy), grid_at(cx, cy + 1), y - ylo, yhi - ylo, sat);
         f2 = lerp_step(grid_at(cx + 1, cy), grid_at(cx + 1, cy + 1), y - ylo, yhi - ylo, sat);
      end
      o.interp_result = 32'(lerp_step(f1, f2, x - xlo, xhi - xlo, sat));
      o.status = sat ? ST_SAT : ST_OK;
      return o;
   endfunction

   function automatic void clear_grid();
      nx = 0;
      ny = 0;
      npts = 0;
      prev_x = 0;
      first_run = 1'b1;
      load_ovf = 1'b0;
   endfunction

   function automatic void load_point(longint x, longint y, longint z);
      if (npts == 0) begin
         x_axis[0] = x;
         nx = 1;
         y_axis[0] = y;
         ny = 1;
         first_run = 1'b1;
         prev_x = x;
      end else if (x != prev_x) begin
         first_run = 1'b0;
         prev_x = x;
         if (nx < XMax) x_axis[nx++] = x;
         else load_ovf = 1'b1;
      end else if (first_run) begin
         if (ny < YMax) y_axis[ny++] = y;
         else load_ovf = 1'b1;
      end
      if (npts < GridSlots) z_grid[npts++] = z;
      else load_ovf = 1'b1;
   endfunction

   // drive one item, wait for acceptance, then update the predictor
   task automatic offer(req_type r, bit typed = 1'b0, rsp_type typed_rsp = '0);
      if (idle_phase == 1 || idle_phase == 3) begin
         while ($urandom_range(99) < ((idle_phase == 1) ? 70 : 13)) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      item_cnt++;
      idle_phase = (item_cnt / 300) % 4;
      case (kind_type'(r.kind))
         KIND_CLEAR: clear_grid();
         KIND_LOAD: load_point(r.coord_x, r.coord_y, r.sample_value);
         KIND_QUERY: pending_rsp.insert(pending_rsp.size(),
                                        typed ? typed_rsp : interpolate(r.coord_x, r.coord_y));
         default: ;
      endcase
   endtask

   function automatic req_type make_req(kind_type k, longint x, longint y, longint z);
      req_type r;
      r.kind = k;
      r.coord_x = 32'(x);
      r.coord_y = 32'(y);
      r.sample_value = 32'(z);
      return r;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic void make_axis(ref longint v[$], input int n);
      longint base;
      int     span;
      bit     wide;
      v.delete();
      wide = $urandom_range(3) == 0;
      base = longint'(int'($urandom)) / 2;
      span = $urandom_range(1 << $urandom_range(4, 29), 1);
      for (int k = 0; k < n; k++) begin
         if (wide) v.insert(v.size(), longint'(int'($urandom)));
         else v.insert(v.size(), base + $urandom_range(span));
      end
      if ($urandom_range(19) == 0) v[1] = v[0];
      v.sort();
   endfunction

   function automatic longint pick_coord(longint v[$]);
      longint lo, hi;
      lo = v[0];
      hi = v[v.size() - 1];
      case ($urandom_range(4))
         0: return v[$urandom_range(v.size() - 1)];
         1: return clip32(lo - $urandom_range(1 << $urandom_range(2, 30)));
         2: return clip32(hi + $urandom_range(1 << $urandom_range(2, 30)));
         3: return longint'(int'($urandom));
         default: return lo + $urandom_range(32'(hi - lo));
      endcase
   endfunction

   function automatic longint pick_value();
      if ($urandom_range(1)) return longint'(int'($urandom));
      return longint'($urandom_range(1 << 20)) - (1 << 19);
   endfunction

   task automatic run_grid();
      longint xs[$], ys[$];
      int     gx, gy, total;
      gx = ($urandom_range(9) == 0) ? $urandom_range(12, 2) : $urandom_range(5, 2);
      gy = ($urandom_range(9) == 0) ? $urandom_range(12, 2) : $urandom_range(5, 2);
      make_axis(xs, gx);
      make_axis(ys, gy);
      offer(make_req(KIND_CLEAR, 0, 0, 0));
      total = gx * gy;
      if ($urandom_range(19) == 0) total--;
      if ($urandom_range(19) == 0) total += $urandom_range(3, 1);
      for (int k = 0; k < total; k++) begin
         offer(make_req(KIND_LOAD, xs[(k / gy) % gx], ys[k % gy], pick_value()));
      end
      repeat ($urandom_range(8, 3)) begin
         if ($urandom_range(9) == 0)
            offer(make_req(KIND_NONE, $urandom, $urandom, $urandom));
         offer(make_req(KIND_QUERY, pick_coord(xs), pick_coord(ys), $urandom));
      end
   endtask

   task automatic run_overflow();
      bit along_x;
      along_x = $urandom_range(1);
      offer(make_req(KIND_CLEAR, 0, 0, 0));
      for (int k = 0; k <= XMax; k++) begin
         offer(make_req(KIND_LOAD, along_x ? k << 16 : 0, along_x ? 0 : k << 16, pick_value()));
      end
      offer(make_req(KIND_QUERY, $urandom, $urandom, $urandom));
   endtask

   // sink: random stalls per phase, long hold-off on request
   always @(posedge clock) begin
      if (hold_off_req) begin
         hold_left = 400;
         hold_off_req = 1'b0;
      end
      if (rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected item actual result=%h status=%0d",
                     $time, rsp_data.interp_result, rsp_data.status);
            fail_cnt++;
         end else begin
            if (rsp_data.interp_result !== pending_rsp[0].interp_result ||
                rsp_data.status !== pending_rsp[0].status) begin
               $display("%0t: mismatch expected result=%h status=%0d actual result=%h status=%0d",
                        $time, pending_rsp[0].interp_result, pending_rsp[0].status,
                        rsp_data.interp_result, rsp_data.status);
               fail_cnt++;
            end
            void'(pending_rsp.pop_front());
         end
      end
      if (reset) rsp_ready <= 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (idle_phase == 2) rsp_ready <= $urandom_range(99) >= 70;
      else if (idle_phase == 3) rsp_ready <= $urandom_range(99) >= 13;
      else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WatchLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      row_type rows[$];
      clear_grid();
      rows = '{
         '{make_req(KIND_QUERY, 0, 0, 0), 1'b1, '{32'sd0, ST_SMALL}},
         '{make_req(KIND_NONE, 0, 0, 0), 1'b0, '0},
         '{make_req(KIND_LOAD, 0, 0, 32'h0001_0000), 1'b0, '0},
         '{make_req(KIND_LOAD, 0, 32'h0001_0000, 32'h0002_0000), 1'b0, '0},
         '{make_req(KIND_QUERY, 0, 0, 0), 1'b1, '{32'sd0, ST_SMALL}},
         '{make_req(KIND_LOAD, 32'h0001_0000, 0, 32'h0003_0000), 1'b0, '0},
         '{make_req(KIND_LOAD, 32'h0001_0000, 32'h0001_0000, 32'h0005_0000), 1'b0, '0},
         '{make_req(KIND_QUERY, 32'h0000_8000, 32'h0000_8000, 0), 1'b0, '0},
         '{make_req(KIND_QUERY, 32'h8000_0000, 32'h8000_0000, 0), 1'b0, '0},
         '{make_req(KIND_QUERY, 32'h7fff_ffff, 32'h7fff_ffff, 0), 1'b0, '0},
         '{make_req(KIND_CLEAR, 0, 0, 0), 1'b0, '0},
         '{make_req(KIND_LOAD, 5, 7, 32'h7fff_ffff), 1'b0, '0},
         '{make_req(KIND_LOAD, 5, 8, 32'h8000_0000), 1'b0, '0},
         '{make_req(KIND_LOAD, 6, 7, 32'h8000_0000), 1'b0, '0},
         '{make_req(KIND_LOAD, 6, 8, 32'h7fff_ffff), 1'b0, '0},
         '{make_req(KIND_QUERY, 5, 7, 0), 1'b0, '0},
         '{make_req(KIND_QUERY, -1, 32'h7fff_ffff, 0), 1'b0, '0},
         '{make_req(KIND_CLEAR, 0, 0, 0), 1'b0, '0},
         '{make_req(KIND_LOAD, 3, 3, 1), 1'b0, '0},
         '{make_req(KIND_LOAD, 3, 3, 2), 1'b0, '0},
         '{make_req(KIND_LOAD, 4, 3, 3), 1'b0, '0},
         '{make_req(KIND_LOAD, 4, 3, 4), 1'b0, '0},
         '{make_req(KIND_QUERY, 0, 0, 0), 1'b1, '{32'sd0, ST_EQUAL}},
         '{make_req(KIND_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff), 1'b0, '0}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[k]) offer(rows[k].req, rows[k].typed, rows[k].rsp);
      hold_off_req = 1'b1;
      while (item_cnt < ItemTarget) begin
         case ($urandom_range(99)) inside
            [0:2]: run_overflow();
            [3:14]: offer(make_req(kind_type'($urandom_range(3)), $urandom, $urandom, $urandom));
            default: run_grid();
         endcase
      end
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (fail_cnt == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
sv/bgi_pkg.sv
sv/bgi_ram.sv
sv/bgi_front.sv
sv/bgi_div.sv
sv/bgi_back.sv
sv/bilinear_grid_interpolator_core.sv
verif/tb_top.sv
